### rtl/las_pkg.sv
// Shared types, codes and timing constants for the LED animation sequencer.
package las_pkg;

  localparam int LED_COUNT_DEF = 8;
  localparam int LED_W         = 8;
  localparam int MS_W          = 9;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  localparam logic [7:0] KEY_FIRST = 8'h31;
  localparam logic [7:0] KEY_LAST  = 8'h39;

  localparam logic [3:0] MODE_IDLE      = 4'd0;
  localparam logic [3:0] MODE_BLINK     = 4'd1;
  localparam logic [3:0] MODE_CHASE_R   = 4'd2;
  localparam logic [3:0] MODE_CHASE_L   = 4'd3;
  localparam logic [3:0] MODE_PINGPONG  = 4'd4;
  localparam logic [3:0] MODE_FILL      = 4'd5;
  localparam logic [3:0] MODE_FILL_EMPT = 4'd6;
  localparam logic [3:0] MODE_ALT       = 4'd7;
  localparam logic [3:0] MODE_PAIR      = 4'd8;
  localparam logic [3:0] MODE_COUNT     = 4'd9;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [MS_W-1:0] MS_BLINK = 9'd200;
  localparam logic [MS_W-1:0] MS_CHASE = 9'd100;
  localparam logic [MS_W-1:0] MS_PING  = 9'd80;
  localparam logic [MS_W-1:0] MS_FILL  = 9'd120;
  localparam logic [MS_W-1:0] MS_HOLD  = 9'd300;
  localparam logic [MS_W-1:0] MS_CLEAR = 9'd200;
  localparam logic [MS_W-1:0] MS_ALT   = 9'd300;
  localparam logic [MS_W-1:0] MS_PAIR  = 9'd90;
  localparam logic [MS_W-1:0] MS_COUNT = 9'd60;

  localparam logic [2:0] ROUNDS_FIVE  = 3'd5;
  localparam logic [2:0] ROUNDS_THREE = 3'd3;
  localparam logic [2:0] ROUNDS_TWO   = 3'd2;

  localparam logic [2:0] ADDR_LED_ACTIVE_LOW = 3'd0;

  typedef struct packed {
    logic       opcode;
    logic [7:0] key_code;
  } in_t;

  typedef struct packed {
    logic [7:0] led_pattern;
    logic       busy_res;
  } out_t;

  typedef struct packed {
    logic [3:0]      mode;
    logic [2:0]      rnd;
    logic [2:0]      pos;
    logic [1:0]      phase;
    logic [MS_W-1:0] ms;
    logic [7:0]      bin;
    logic [LED_W-1:0] lit;
  } anim_state_t;

endpackage

### rtl/las_step.sv
// Next-state and result logic for one tick or key request.
module las_step #(
  parameter int LED_COUNT = las_pkg::LED_COUNT_DEF
) (
  input  las_pkg::anim_state_t cur_st,
  input  las_pkg::in_t         req,
  input  logic                 active_low,
  output las_pkg::anim_state_t nxt_st,
  output las_pkg::out_t        res
);
  import las_pkg::*;

  localparam logic [7:0] LED_MASK = 8'((9'd1 << LED_COUNT) - 9'd1);
  localparam logic [2:0] LAST     = 3'(LED_COUNT - 1);

  typedef struct packed {
    anim_state_t st;
    logic        cont;
  } adv_t;

  function automatic logic [7:0] bit_at(input logic [2:0] p);
    bit_at = (8'd1 << p) & LED_MASK;
  endfunction

  function automatic anim_state_t show_step(input anim_state_t s);
    anim_state_t o;
    o = s;
    unique case (s.mode)
      MODE_BLINK: begin
        o.lit = (s.phase == PH_FIRST) ? LED_MASK : 8'd0;
        o.ms  = MS_BLINK;
      end
      MODE_CHASE_R, MODE_CHASE_L: begin
        o.lit = bit_at(s.pos);
        o.ms  = MS_CHASE;
      end
      MODE_PINGPONG: begin
        o.lit = bit_at(s.pos);
        o.ms  = MS_PING;
      end
      MODE_FILL: begin
        if (s.phase == PH_FIRST) begin
          o.lit = s.lit | bit_at(s.pos);
          o.ms  = MS_FILL;
        end else if (s.phase == PH_SECOND) begin
          o.ms  = MS_HOLD;
        end else begin
          o.lit = 8'd0;
          o.ms  = MS_CLEAR;
        end
      end
      MODE_FILL_EMPT: begin
        o.lit = (s.phase == PH_FIRST) ? (s.lit | bit_at(s.pos)) : (s.lit & ~bit_at(s.pos));
        o.ms  = MS_PING;
      end
      MODE_ALT: begin
        o.lit = ((s.phase == PH_FIRST) ? 8'h55 : 8'hAA) & LED_MASK;
        o.ms  = MS_ALT;
      end
      MODE_PAIR: begin
        o.lit = (s.phase == PH_FIRST) ? (bit_at(s.pos) | bit_at(s.pos + 3'd1))
                                      : (bit_at(s.pos) | bit_at(s.pos - 3'd1));
        o.ms  = MS_PAIR;
      end
      MODE_COUNT: begin
        o.lit = s.bin & LED_MASK;
        o.ms  = MS_COUNT;
      end
      default: begin
        o.lit = 8'd0;
        o.ms  = '0;
      end
    endcase
    show_step = o;
  endfunction

  function automatic adv_t next_round(input anim_state_t s, input logic [2:0] rounds,
                                      input logic [2:0] start);
    adv_t a;
    a.st       = s;
    a.st.phase = PH_FIRST;
    a.st.pos   = start;
    a.st.rnd   = s.rnd + 3'd1;
    a.cont     = (a.st.rnd < rounds);
    next_round = a;
  endfunction

  function automatic adv_t advance(input anim_state_t s);
    adv_t a;
    a.st = s;
    a.cont = 1'b1;
    unique case (s.mode)
      MODE_BLINK, MODE_ALT: begin
        if (s.phase == PH_FIRST) a.st.phase = PH_SECOND;
        else a = next_round(s, ROUNDS_FIVE, 3'd0);
      end
      MODE_CHASE_R: begin
        if (s.pos < LAST) a.st.pos = s.pos + 3'd1;
        else a = next_round(s, ROUNDS_THREE, 3'd0);
      end
      MODE_CHASE_L: begin
        if (s.pos > 3'd0) a.st.pos = s.pos - 3'd1;
        else a = next_round(s, ROUNDS_THREE, LAST);
      end
      MODE_PINGPONG, MODE_FILL_EMPT: begin
        if (s.phase == PH_FIRST) begin
          if (s.pos < LAST) begin
            a.st.pos = s.pos + 3'd1;
          end else begin
            a.st.phase = PH_SECOND;
            a.st.pos   = LAST;
          end
        end else if (s.pos > 3'd0) begin
          a.st.pos = s.pos - 3'd1;
        end else begin
          a = next_round(s, ROUNDS_TWO, 3'd0);
        end
      end
      MODE_FILL: begin
        if (s.phase == PH_FIRST) begin
          if (s.pos < LAST) a.st.pos = s.pos + 3'd1;
          else a.st.phase = PH_SECOND;
        end else if (s.phase == PH_SECOND) begin
          a.st.phase = PH_THIRD;
        end else begin
          a = next_round(s, ROUNDS_TWO, 3'd0);
        end
      end
      MODE_PAIR: begin
        if (s.phase == PH_FIRST) begin
          if ({1'b0, s.pos} + 4'd1 < {1'b0, LAST}) begin
            a.st.pos = s.pos + 3'd1;
          end else begin
            a.st.phase = PH_SECOND;
            a.st.pos   = LAST;
          end
        end else if (s.pos > 3'd1) begin
          a.st.pos = s.pos - 3'd1;
        end else begin
          a = next_round(s, ROUNDS_THREE, 3'd0);
        end
      end
      MODE_COUNT: begin
        a.st.bin = s.bin + 8'd1;
        a.cont   = (a.st.bin != 8'd0);
      end
      default: a.cont = 1'b0;
    endcase
    advance = a;
  endfunction

  anim_state_t     start_st;
  anim_state_t     tick_st;
  adv_t            adv;
  logic [MS_W-1:0] ms_dec;
  logic [7:0]      pat;

  always_comb begin
    start_st      = '0;
    start_st.mode = req.key_code[3:0];
    if (req.key_code[3:0] == MODE_CHASE_L) start_st.pos = LAST;
    start_st = show_step(start_st);

    ms_dec     = (cur_st.ms != '0) ? cur_st.ms - 9'd1 : cur_st.ms;
    tick_st    = cur_st;
    tick_st.ms = ms_dec;
    adv        = advance(tick_st);

    nxt_st = cur_st;
    if (req.opcode == OP_KEY) begin
      if (cur_st.mode == MODE_IDLE && req.key_code >= KEY_FIRST &&
          req.key_code <= KEY_LAST) begin
        nxt_st = start_st;
      end
    end else if (cur_st.mode != MODE_IDLE) begin
      if (ms_dec != '0) nxt_st = tick_st;
      else if (adv.cont) nxt_st = show_step(adv.st);
      else nxt_st = '0;
    end

    pat = nxt_st.lit & LED_MASK;
    if (active_low) pat = ~pat & LED_MASK;
    res.led_pattern = pat;
    res.busy_res    = (nxt_st.mode != MODE_IDLE);
  end

endmodule

### rtl/led_animation_sequencer.sv
// LED animation sequencer top level: request channels, config register and state.
// Each request (a one-millisecond tick or a key press) yields exactly one result: the
// LED vector after polarity and a busy flag. A request is accepted every cycle while the
// result register is empty or being drained; its result appears in the cycle after
// acceptance, set by a single register stage after the step logic. Keys '1' to '9'
// start an animation only while idle. led_active_low sits at byte address 0 and should
// be written only while no request is in flight. Bits at and above LED_COUNT read zero.
module led_animation_sequencer #(
  parameter int LED_COUNT = las_pkg::LED_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  las_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output las_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import las_pkg::*;

  localparam logic [7:0] LED_MASK = 8'((9'd1 << LED_COUNT) - 9'd1);

  anim_state_t state_r;
  anim_state_t state_nxt;
  out_t        out_r;
  out_t        res;
  logic        out_valid_r;
  logic        led_active_low_r;
  logic        in_fire;
  logic        cfg_sel;

  las_step #(
    .LED_COUNT(LED_COUNT)
  ) u_step (
    .cur_st    (state_r),
    .req       (in_data),
    .active_low(led_active_low_r),
    .nxt_st    (state_nxt),
    .res       (res)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_sel   = (paddr[2] == ADDR_LED_ACTIVE_LOW[2]);
  assign prdata    = cfg_sel ? {31'd0, led_active_low_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= '0;
      out_valid_r      <= 1'b0;
      led_active_low_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && pready && cfg_sel) begin
        led_active_low_r <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |->
      out_data.led_pattern == (led_active_low_r ? LED_MASK : 8'd0))
    else $error("idle result shows lit LEDs");

  a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.led_pattern & ~LED_MASK) == 8'd0)
    else $error("LED bits beyond LED_COUNT driven");

  a_step_timer: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode != MODE_IDLE |-> state_r.ms != '0)
    else $error("running animation with expired step timer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  a_busy_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_data.busy_res == (state_r.mode != MODE_IDLE))
    else $error("busy flag disagrees with state");
`endif

endmodule
